FILE: rtl/swph_pkg.sv
// Shared types and constants for the stopwatch block.
// No dependencies; used by the channel interfaces and the top level.
package swph_pkg;

  localparam int unsigned FuncW = 3;
  localparam int unsigned CntW  = 16;
  localparam int unsigned CfgW  = 16;

  localparam logic [CfgW-1:0] TpsReset  = 16'd100;
  localparam logic [CfgW-1:0] HoldReset = 16'd300;
  localparam logic [CntW-1:0] CntMax    = 16'hFFFF;

  typedef enum logic [FuncW-1:0] {
    FUNC_TICK  = 3'd0,
    FUNC_START = 3'd1,
    FUNC_PAUSE = 3'd2,
    FUNC_CLEAR = 3'd3,
    FUNC_EXIT  = 3'd4
  } func_e;

  typedef enum logic {
    CFG_TPS  = 1'b0,
    CFG_HOLD = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] display_bcd;
    logic        display_write;
    logic        running;
    logic        paused_flag;
    logic        finished;
  } res_t;

endpackage

FILE: rtl/swph_if.sv
// Valid/ready channel interfaces for the stopwatch block.
// Depends on swph_pkg for field widths.
interface swph_in_if;
  logic                          valid;
  logic                          ready;
  logic [swph_pkg::FuncW-1:0]    func;
  logic                          exit_level;

  modport source (output valid, func, exit_level, input ready);
  modport sink   (input valid, func, exit_level, output ready);
endinterface

interface swph_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] display_bcd;
  logic        display_write;
  logic        running;
  logic        paused_flag;
  logic        finished;

  modport source (output valid, display_bcd, display_write, running, paused_flag, finished,
                  input ready);
  modport sink   (input valid, display_bcd, display_write, running, paused_flag, finished,
                  output ready);
endinterface

FILE: rtl/stopwatch_pause_hold_exit.sv
// Stopwatch top level: input register, event update logic, result register.
// An event passes through the input register and then the result register before its result transfers.
// Throughput: one event per cycle; both stages advance whenever the result reg frees.
// Reset (rst_n low, synchronous): all counters and flags clear, ticks_per_second = 100,
// hold_ticks = 300, both pipeline stages empty.
// Depends on swph_pkg and swph_if.
module stopwatch_pause_hold_exit (
  input  logic                        clk,
  input  logic                        rst_n,
  swph_in_if.sink                     in_ch,
  swph_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [swph_pkg::CfgW-1:0]   cfg_data
);

  // configuration
  logic [swph_pkg::CfgW-1:0] tps_r, hold_ticks_r;

  // input stage
  logic                       s1_valid_r;
  logic [swph_pkg::FuncW-1:0] s1_func_r;
  logic                       s1_level_r;

  // result stage
  logic           out_valid_r;
  swph_pkg::res_t out_res_r, res_nxt;

  // stopwatch state; elapsed time kept directly as BCD digits
  logic [swph_pkg::CntW-1:0] ticks_left_r, ticks_left_nxt;
  logic [swph_pkg::CntW-1:0] saved_r, saved_nxt;
  logic [swph_pkg::CntW-1:0] hold_cnt_r, hold_cnt_nxt;
  logic [3:0] sec1_r, sec1_nxt, min1_r, min1_nxt;
  logic [2:0] sec10_r, sec10_nxt, min10_r, min10_nxt;
  logic armed_r, armed_nxt, paused_r, paused_nxt, started_r, started_nxt;
  logic hold_act_r, hold_act_nxt;

  logic advance, s1_fire, wrote, fin;
  logic [swph_pkg::CntW-1:0] hold_inc;

  assign advance  = !out_valid_r || out_ch.ready;
  assign s1_fire  = s1_valid_r && advance;
  assign in_ch.ready = !s1_valid_r || advance;

  assign hold_inc = (hold_cnt_r != swph_pkg::CntMax) ? hold_cnt_r + 16'd1 : hold_cnt_r;

  always_comb begin
    ticks_left_nxt = ticks_left_r;
    saved_nxt      = saved_r;
    hold_cnt_nxt   = hold_cnt_r;
    sec1_nxt       = sec1_r;
    sec10_nxt      = sec10_r;
    min1_nxt       = min1_r;
    min10_nxt      = min10_r;
    armed_nxt      = armed_r;
    paused_nxt     = paused_r;
    started_nxt    = started_r;
    hold_act_nxt   = hold_act_r;
    wrote          = 1'b0;
    fin            = 1'b0;

    case (s1_func_r)
      swph_pkg::FUNC_TICK: begin
        if (armed_r) begin
          if (ticks_left_r[15:1] == 15'd0) begin
            // second done: BCD increment, wrap 59:59 -> 00:00
            wrote          = 1'b1;
            ticks_left_nxt = tps_r;
            if (sec1_r != 4'd9) begin
              sec1_nxt = sec1_r + 4'd1;
            end else begin
              sec1_nxt = 4'd0;
              if (sec10_r != 3'd5) begin
                sec10_nxt = sec10_r + 3'd1;
              end else begin
                sec10_nxt = 3'd0;
                if (min1_r != 4'd9) begin
                  min1_nxt = min1_r + 4'd1;
                end else begin
                  min1_nxt  = 4'd0;
                  min10_nxt = (min10_r != 3'd5) ? min10_r + 3'd1 : 3'd0;
                end
              end
            end
          end else begin
            ticks_left_nxt = ticks_left_r - 16'd1;
          end
        end
        if (hold_act_r) begin
          hold_cnt_nxt = hold_inc;
          if (hold_inc >= hold_ticks_r) begin
            // long exit hold: wipe everything
            ticks_left_nxt = '0;
            saved_nxt      = '0;
            hold_cnt_nxt   = '0;
            sec1_nxt       = '0;
            sec10_nxt      = '0;
            min1_nxt       = '0;
            min10_nxt      = '0;
            armed_nxt      = 1'b0;
            paused_nxt     = 1'b0;
            started_nxt    = 1'b0;
            hold_act_nxt   = 1'b0;
            wrote          = 1'b1;
            fin            = 1'b1;
          end
        end
      end
      swph_pkg::FUNC_START: begin
        if (!started_r && !paused_r) begin
          armed_nxt      = 1'b1;
          ticks_left_nxt = tps_r;
          started_nxt    = 1'b1;
        end
      end
      swph_pkg::FUNC_PAUSE: begin
        if (!paused_r) begin
          saved_nxt   = armed_r ? ticks_left_r : tps_r;
          armed_nxt   = 1'b0;
          started_nxt = 1'b0;
          paused_nxt  = 1'b1;
        end else begin
          paused_nxt     = 1'b0;
          started_nxt    = 1'b1;
          armed_nxt      = 1'b1;
          ticks_left_nxt = saved_r;
        end
      end
      swph_pkg::FUNC_CLEAR: begin
        if (started_r || paused_r) begin
          sec1_nxt  = '0;
          sec10_nxt = '0;
          min1_nxt  = '0;
          min10_nxt = '0;
          wrote     = 1'b1;
          if (paused_r) begin
            saved_nxt   = tps_r;
            armed_nxt   = 1'b0;
            started_nxt = 1'b0;
          end else begin
            armed_nxt      = 1'b1;
            ticks_left_nxt = tps_r;
            started_nxt    = 1'b1;
          end
        end
      end
      swph_pkg::FUNC_EXIT: begin
        if (!s1_level_r) begin
          hold_act_nxt = 1'b1;
          hold_cnt_nxt = '0;
        end else begin
          hold_act_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase

    res_nxt.display_bcd   = {1'b0, min10_nxt, min1_nxt, 1'b0, sec10_nxt, sec1_nxt};
    res_nxt.display_write = wrote;
    res_nxt.running       = armed_nxt;
    res_nxt.paused_flag   = paused_nxt;
    res_nxt.finished      = fin;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r        <= swph_pkg::TpsReset;
      hold_ticks_r <= swph_pkg::HoldReset;
    end else if (cfg_we) begin
      case (cfg_index)
        swph_pkg::CFG_TPS:  tps_r        <= cfg_data;
        swph_pkg::CFG_HOLD: hold_ticks_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_func_r  <= in_ch.func;
      s1_level_r <= in_ch.exit_level;
    end
    if (s1_fire) begin
      out_res_r <= res_nxt;
    end
  end

  // stopwatch state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_left_r <= '0;
      saved_r      <= '0;
      hold_cnt_r   <= '0;
      sec1_r       <= '0;
      sec10_r      <= '0;
      min1_r       <= '0;
      min10_r      <= '0;
      armed_r      <= 1'b0;
      paused_r     <= 1'b0;
      started_r    <= 1'b0;
      hold_act_r   <= 1'b0;
    end else if (s1_fire) begin
      ticks_left_r <= ticks_left_nxt;
      saved_r      <= saved_nxt;
      hold_cnt_r   <= hold_cnt_nxt;
      sec1_r       <= sec1_nxt;
      sec10_r      <= sec10_nxt;
      min1_r       <= min1_nxt;
      min10_r      <= min10_nxt;
      armed_r      <= armed_nxt;
      paused_r     <= paused_nxt;
      started_r    <= started_nxt;
      hold_act_r   <= hold_act_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.display_bcd   = out_res_r.display_bcd;
  assign out_ch.display_write = out_res_r.display_write;
  assign out_ch.running       = out_res_r.running;
  assign out_ch.paused_flag   = out_res_r.paused_flag;
  assign out_ch.finished      = out_res_r.finished;

`ifndef SYNTH
  // a finish leaves a blank, idle watch
  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.finished |->
      out_res_r.display_bcd == 16'd0 && out_res_r.display_write &&
      !out_res_r.running && !out_res_r.paused_flag)
    else $error("finish did not clear the watch");

  a_not_armed_paused: assert property (@(posedge clk) disable iff (!rst_n)
    !(armed_r && paused_r))
    else $error("countdown armed while paused");

  a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
    sec1_r <= 4'd9 && sec10_r <= 3'd5 && min1_r <= 4'd9 && min10_r <= 3'd5)
    else $error("time digits out of range");

  a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_func_r))
    else $error("input stage lost an event under stall");

  a_state_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> $stable(armed_r) && $stable(paused_r) && $stable(hold_act_r))
    else $error("state changed without an event");
`endif

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the stopwatch_pause_hold_exit block.
// Depends on swph_pkg and the swph_in_if / swph_out_if channel interfaces.
module tb;

  localparam int unsigned CycleLimit = 400000;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_we;
  logic                      cfg_index;
  logic [swph_pkg::CfgW-1:0] cfg_data;

  swph_in_if  in_ch ();
  swph_out_if out_ch ();

  stopwatch_pause_hold_exit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // predictor copy of the registers and the watch state
  logic [15:0] w_tps, w_hold;
  logic [15:0] w_ticks_left, w_saved, w_hold_cnt, w_shown;
  logic [11:0] w_secs;
  logic        w_armed, w_paused, w_started, w_hold_on;

  swph_pkg::res_t pending_display[$];
  int unsigned    fail_count  = 0;
  int unsigned    cycle_count = 0;
  bit             idle_en     = 1'b1;

  function automatic logic [15:0] secs_to_bcd(input logic [11:0] secs);
    int unsigned mins, rem;
    mins = (secs / 60) % 60;
    rem  = secs % 60;
    return {4'(mins / 10), 4'(mins % 10), 4'(rem / 10), 4'(rem % 10)};
  endfunction

  task automatic clear_watch();
    w_ticks_left = '0;
    w_saved      = '0;
    w_secs       = '0;
    w_armed      = 1'b0;
    w_paused     = 1'b0;
    w_started    = 1'b0;
    w_hold_cnt   = '0;
    w_hold_on    = 1'b0;
    w_shown      = '0;
  endtask

  // one event in, one expected display result out
  task automatic advance_watch(input logic [swph_pkg::FuncW-1:0] f, input logic lvl);
    logic wrote, fin;
    swph_pkg::res_t r;
    wrote = 1'b0;
    fin   = 1'b0;
    case (f)
      swph_pkg::FUNC_TICK: begin
        if (w_armed) begin
          if (w_ticks_left <= 16'd1) begin
            w_secs       = (w_secs == 12'd3599) ? 12'd0 : w_secs + 12'd1;
            w_shown      = secs_to_bcd(w_secs);
            wrote        = 1'b1;
            w_ticks_left = w_tps;
          end else begin
            w_ticks_left = w_ticks_left - 16'd1;
          end
        end
        // exit hold is evaluated after the countdown; a finish wins
        if (w_hold_on) begin
          if (w_hold_cnt < swph_pkg::CntMax) w_hold_cnt = w_hold_cnt + 16'd1;
          if (w_hold_cnt >= w_hold) begin
            clear_watch();
            wrote = 1'b1;
            fin   = 1'b1;
          end
        end
      end
      swph_pkg::FUNC_START: begin
        if (!w_started && !w_paused) begin
          w_armed      = 1'b1;
          w_ticks_left = w_tps;
          w_started    = 1'b1;
        end
      end
      swph_pkg::FUNC_PAUSE: begin
        if (!w_paused) begin
          w_saved   = w_armed ? w_ticks_left : w_tps;
          w_armed   = 1'b0;
          w_started = 1'b0;
          w_paused  = 1'b1;
        end else begin
          w_paused     = 1'b0;
          w_started    = 1'b1;
          w_armed      = 1'b1;
          w_ticks_left = w_saved;
        end
      end
      swph_pkg::FUNC_CLEAR: begin
        if (w_started || w_paused) begin
          w_secs  = '0;
          w_shown = '0;
          wrote   = 1'b1;
          if (w_paused) begin
            w_saved   = w_tps;
            w_armed   = 1'b0;
            w_started = 1'b0;
          end else begin
            w_armed      = 1'b1;
            w_ticks_left = w_tps;
            w_started    = 1'b1;
          end
        end
      end
      swph_pkg::FUNC_EXIT: begin
        if (!lvl) begin
          w_hold_on  = 1'b1;
          w_hold_cnt = '0;
        end else begin
          w_hold_on = 1'b0;
        end
      end
      default: ;
    endcase
    r.display_bcd   = w_shown;
    r.display_write = wrote;
    r.running       = w_armed;
    r.paused_flag   = w_paused;
    r.finished      = fin;
    pending_display.push_back(r);
  endtask

  // predict on input transfer, check on output transfer
  always @(posedge clk) begin
    swph_pkg::res_t got, want;
    if (rst_n === 1'b1 && in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
      advance_watch(in_ch.func, in_ch.exit_level);
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.display_bcd   = out_ch.display_bcd;
      got.display_write = out_ch.display_write;
      got.running       = out_ch.running;
      got.paused_flag   = out_ch.paused_flag;
      got.finished      = out_ch.finished;
      if (pending_display.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: bcd=%h wr=%b run=%b pause=%b fin=%b",
                   got.display_bcd, got.display_write, got.running,
                   got.paused_flag, got.finished);
      end else begin
        want = pending_display.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("bad result: exp bcd=%h wr=%b run=%b pause=%b fin=%b",
                     want.display_bcd, want.display_write, want.running,
                     want.paused_flag, want.finished);
            $display("            got bcd=%h wr=%b run=%b pause=%b fin=%b",
                     got.display_bcd, got.display_write, got.running,
                     got.paused_flag, got.finished);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("stopwatch_pause_hold_exit: mismatch");
      $finish;
    end
  end

  // result side: random stall before each transfer
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = idle_en ? $urandom_range(0, 11) : 0;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  task automatic send_event(input logic [swph_pkg::FuncW-1:0] f, input logic lvl);
    int unsigned gap;
    gap = idle_en ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= f;
    in_ch.exit_level <= lvl;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // let the last input transfer reach the queue before waiting for it to drain
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_display.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] tps, input logic [15:0] hold);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= swph_pkg::CFG_TPS;
    cfg_data  <= tps;
    @(posedge clk);
    cfg_index <= swph_pkg::CFG_HOLD;
    cfg_data  <= hold;
    @(posedge clk);
    cfg_we <= 1'b0;
    w_tps  = tps;
    w_hold = hold;
  endtask

  task automatic test_reset_defaults();
    idle_en = 1'b1;
    send_event(swph_pkg::FUNC_START, 1'b1);
    send_event(swph_pkg::FUNC_TICK, 1'b1);
    send_event(swph_pkg::FUNC_PAUSE, 1'b0);
    send_event(swph_pkg::FUNC_TICK, 1'b0);
    send_event(swph_pkg::FUNC_PAUSE, 1'b1);
    send_event(swph_pkg::FUNC_CLEAR, 1'b1);
    send_event(swph_pkg::FUNC_EXIT, 1'b0);
    send_event(swph_pkg::FUNC_TICK, 1'b1);
    send_event(swph_pkg::FUNC_EXIT, 1'b1);
  endtask

  task automatic test_event_codes();
    set_config(16'd2, 16'd2);
    idle_en = 1'b1;
    send_event(swph_pkg::FUNC_EXIT, 1'b1);
    send_event(swph_pkg::FUNC_CLEAR, 1'b0);
    send_event(swph_pkg::FUNC_TICK, 1'b0);
    send_event(3'd5, 1'b1);
    send_event(3'd6, 1'b0);
    send_event(3'd7, 1'b1);
    send_event(swph_pkg::FUNC_PAUSE, 1'b0);    // pause from idle saves a full second
    send_event(swph_pkg::FUNC_START, 1'b1);    // ignored while paused
    send_event(swph_pkg::FUNC_CLEAR, 1'b1);    // stays paused
    send_event(swph_pkg::FUNC_PAUSE, 1'b1);    // resume
    send_event(swph_pkg::FUNC_START, 1'b0);    // ignored while running
    send_event(swph_pkg::FUNC_TICK, 1'b0);
    send_event(swph_pkg::FUNC_TICK, 1'b1);
    send_event(swph_pkg::FUNC_EXIT, 1'b0);
    send_event(swph_pkg::FUNC_TICK, 1'b1);
    send_event(swph_pkg::FUNC_EXIT, 1'b1);     // release cancels the hold
    send_event(swph_pkg::FUNC_TICK, 1'b0);
    send_event(swph_pkg::FUNC_EXIT, 1'b0);
    send_event(swph_pkg::FUNC_TICK, 1'b0);
    send_event(swph_pkg::FUNC_TICK, 1'b0);     // rollover and finish together
    send_event(swph_pkg::FUNC_START, 1'b0);
    send_event(swph_pkg::FUNC_CLEAR, 1'b0);
    send_event(swph_pkg::FUNC_TICK, 1'b1);
  endtask

  task automatic test_zero_registers();
    set_config(16'd0, 16'd0);
    idle_en = 1'b1;
    send_event(swph_pkg::FUNC_START, 1'b0);
    send_event(swph_pkg::FUNC_TICK, 1'b0);
    send_event(swph_pkg::FUNC_TICK, 1'b1);
    send_event(swph_pkg::FUNC_EXIT, 1'b0);
    send_event(swph_pkg::FUNC_TICK, 1'b0);
    send_event(swph_pkg::FUNC_PAUSE, 1'b0);
    send_event(swph_pkg::FUNC_PAUSE, 1'b0);
    send_event(swph_pkg::FUNC_TICK, 1'b0);
  endtask

  // one tick per second, carry through 09:59 into the tens of minutes
  task automatic test_display_wrap();
    set_config(16'd1, 16'hFFFF);
    idle_en = 1'b0;
    send_event(swph_pkg::FUNC_START, 1'b0);
    repeat (605) send_event(swph_pkg::FUNC_TICK, 1'b0);
    send_event(swph_pkg::FUNC_CLEAR, 1'b0);
  endtask

  task automatic send_random_event();
    int unsigned                pick;
    logic [swph_pkg::FuncW-1:0] f;
    logic                       lvl;
    pick = $urandom_range(0, 99);
    lvl  = 1'($urandom_range(0, 1));
    if (pick < 55)      f = swph_pkg::FUNC_TICK;
    else if (pick < 63) f = swph_pkg::FUNC_START;
    else if (pick < 71) f = swph_pkg::FUNC_PAUSE;
    else if (pick < 77) f = swph_pkg::FUNC_CLEAR;
    else if (pick < 92) f = swph_pkg::FUNC_EXIT;
    else                f = 3'($urandom_range(5, 7));
    send_event(f, lvl);
  endtask

  task automatic test_random_mix();
    logic [15:0] tps_set[8]  = '{16'd1, 16'hFFFF, 16'd2, 16'd3, 16'd1, 16'd6, 16'hFFFF, 16'd4};
    logic [15:0] hold_set[8] = '{16'd1, 16'hFFFF, 16'd5, 16'd12, 16'd40, 16'd3, 16'd1, 16'd25};
    for (int p = 0; p < 8; p++) begin
      set_config(tps_set[p], hold_set[p]);
      for (int n = 0; n < 170; n++) begin
        if (n % 64 == 0) idle_en = ($urandom_range(0, 3) != 0);
        send_random_event();
      end
    end
  endtask

  initial begin
    in_ch.valid      <= 1'b0;
    in_ch.func       <= swph_pkg::FUNC_TICK;
    in_ch.exit_level <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= swph_pkg::CFG_TPS;
    cfg_data         <= '0;
    rst_n            <= 1'b0;
    w_tps  = swph_pkg::TpsReset;
    w_hold = swph_pkg::HoldReset;
    clear_watch();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_event_codes();
    test_zero_registers();
    test_display_wrap();
    test_random_mix();
    wait_idle();

    if (fail_count == 0) begin
      $display("stopwatch_pause_hold_exit: match");
    end else begin
      $display("stopwatch_pause_hold_exit: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/swph_pkg.sv
rtl/swph_if.sv
rtl/stopwatch_pause_hold_exit.sv
tb/sv/tb.sv
